FILE: rtl/core/mbrot_pkg.sv
package mbrot_pkg;

  // Fixed-point format of c and z: signed Q4.FRAC_BITS.
  localparam int FRAC_BITS = 28;
  localparam int Z_W       = FRAC_BITS + 4;
  localparam int P_W       = 2 * Z_W;

  // Item and configuration field widths.
  localparam int POS_W     = 12;
  localparam int SIDE_W    = 13;
  localparam int ITER_W    = 16;
  localparam int INT_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_SIDE  = 4096;

  // Shared restoring divider: for the plane mapping the dividend is pos*3 followed by FRAC_BITS zeros.
  localparam int POS3_W     = POS_W + 2;
  localparam int DIV_DVD_W  = POS3_W + FRAC_BITS;
  localparam int DIV_DSR_W  = ITER_W;
  localparam int DIV_CNT_W  = $clog2(DIV_DVD_W);
  localparam int INT_NUM_W  = ITER_W + INT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SIDE_W-1:0] RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [SIDE_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [ITER_W-1:0] RST_MAX_ITERATIONS = 16'd256;

  // Plane origin of each axis and the squared escape radius.
  localparam logic signed [Z_W-1:0] RE_START = Z_W'(-(longint'(2) << FRAC_BITS));
  localparam logic signed [Z_W-1:0] IM_START = Z_W'(-(longint'(3) << (FRAC_BITS - 1)));
  localparam logic [P_W-1:0]        FOUR_SQ  = P_W'(longint'(4) << (2 * FRAC_BITS));

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_ITER_ADD,
    ST_ITER_MUL,
    ST_DIV_INT,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/mbrot_div.sv
module mbrot_div
  import mbrot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DSR_W-1:0] rem_r, rem_nxt;
  logic [DIV_DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_DVD_W-1:0] quo_r, quo_nxt;
  logic [DIV_DSR_W:0]   trial;
  logic [DIV_DSR_W:0]   diff;
  logic                 fits;

  // One quotient bit per cycle: shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = !diff[DIV_DSR_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
      quo_nxt = {quo_r[DIV_DVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_DVD_W - 1);
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("divider done without a finished run");
`endif

endmodule

FILE: rtl/core/mandelbrot_escape_pixel_top.sv
// Two 42-bit divider passes map the pixel onto the plane, a third one scales the gray level
// of an escaped point, and each complex step computes the products of z (ST_ITER_MUL) and then
// the update and escape test (ST_ITER_ADD).
// Throughput: one item at a time; the next item can be taken in the cycle out_valid rises.
// Reset: synchronous, active low; configuration returns to 640 x 480, limit 256.
module mandelbrot_escape_pixel_top
  import mbrot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     in_pixel_column,
  input  logic [POS_W-1:0]     in_pixel_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [INT_W-1:0]     out_intensity,
  output logic [ITER_W-1:0]    out_iteration_count,
  output logic                 out_inside_set
);

  state_t state_r, state_nxt;

  logic [SIDE_W-1:0] width_r, height_r;
  logic [ITER_W-1:0] iter_r;

  logic [POS_W-1:0]  row_r, hm1_r;
  logic [ITER_W-1:0] lim_r, count_r;
  logic signed [Z_W-1:0] cr_r, ci_r, zr_r, zi_r;
  logic signed [P_W-1:0] p_rr_r, p_ii_r, p_ri_r;
  logic              first_r;
  logic [INT_W-1:0]  int_r;
  logic              inside_r;

  logic              out_valid_r;
  logic [INT_W-1:0]  out_intensity_r;
  logic [ITER_W-1:0] out_count_r;
  logic              out_inside_r;

  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [POS_W-1:0]  w_m1, h_m1;
  logic [POS_W-1:0]  col_c, row_c;
  logic [ITER_W-1:0] lim_eff;
  logic [POS3_W-1:0] col3, row3;
  logic [INT_NUM_W-1:0] int_num;
  logic              in_take, out_load;

  logic signed [P_W-1:0] re_diff, re_sh, im_dbl, im_sh;
  logic signed [Z_W-1:0] zr_new, zi_new;
  logic [P_W-1:0]        mag;
  logic                  escape;
  logic [ITER_W:0]       count_inc;
  logic                  last_iter;

  div_req_t             div_req;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] div_quo;

  mbrot_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      iter_r   <= RST_MAX_ITERATIONS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    width_r  <= cfg_data[SIDE_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r <= cfg_data[SIDE_W-1:0];
        CFG_MAX_ITERATIONS: iter_r   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size, limit and position of the incoming item.
  always_comb begin
    w_eff = width_r;
    if (width_r < SIDE_W'(2)) w_eff = SIDE_W'(2);
    else if (width_r > SIDE_W'(MAX_SIDE)) w_eff = SIDE_W'(MAX_SIDE);
    h_eff = height_r;
    if (height_r < SIDE_W'(2)) h_eff = SIDE_W'(2);
    else if (height_r > SIDE_W'(MAX_SIDE)) h_eff = SIDE_W'(MAX_SIDE);
    w_m1    = POS_W'(w_eff - SIDE_W'(1));
    h_m1    = POS_W'(h_eff - SIDE_W'(1));
    col_c   = (in_pixel_column > w_m1) ? w_m1 : in_pixel_column;
    row_c   = (in_pixel_row > h_m1) ? h_m1 : in_pixel_row;
    lim_eff = (iter_r == '0) ? ITER_W'(1) : iter_r;
  end

  assign col3    = POS3_W'(col_c) * POS3_W'(3);
  assign row3    = POS3_W'(row_r) * POS3_W'(3);
  // 255*count as count*256 - count.
  assign int_num = {count_r, INT_W'(0)} - INT_NUM_W'(count_r);

  // Complex update from the registered products, and the escape test on them.
  assign re_diff   = p_rr_r - p_ii_r;
  assign re_sh     = re_diff >>> FRAC_BITS;
  assign im_dbl    = p_ri_r <<< 1;
  assign im_sh     = im_dbl >>> FRAC_BITS;
  assign zr_new    = $signed(re_sh[Z_W-1:0]) + cr_r;
  assign zi_new    = $signed(im_sh[Z_W-1:0]) + ci_r;
  assign mag       = $unsigned(p_rr_r) + $unsigned(p_ii_r);
  assign escape    = mag > FOUR_SQ;
  assign count_inc = {1'b0, count_r} + (ITER_W + 1)'(1);
  assign last_iter = count_inc == {1'b0, lim_r};

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  // Sequencer: next state and divider requests.
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = {col3, FRAC_BITS'(0)};
    div_req.divisor  = DIV_DSR_W'(w_m1);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_RE;
        end
      end
      ST_DIV_RE: begin
        div_req.dividend = {row3, FRAC_BITS'(0)};
        div_req.divisor  = DIV_DSR_W'(hm1_r);
        if (div_done) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_IM;
        end
      end
      ST_DIV_IM: begin
        if (div_done) state_nxt = ST_ITER_ADD;
      end
      ST_ITER_ADD: begin
        div_req.dividend = DIV_DVD_W'(int_num);
        div_req.divisor  = lim_r;
        if (first_r) begin
          state_nxt = ST_ITER_MUL;
        end else if (escape) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_INT;
        end else if (last_iter) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_ITER_MUL;
        end
      end
      ST_ITER_MUL: state_nxt = ST_ITER_ADD;
      ST_DIV_INT: begin
        if (div_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Per-item datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          row_r <= row_c;
          hm1_r <= h_m1;
          lim_r <= lim_eff;
        end
      end
      ST_DIV_RE: begin
        if (div_done) cr_r <= RE_START + $signed(div_quo[Z_W-1:0]);
      end
      ST_DIV_IM: begin
        if (div_done) begin
          ci_r     <= IM_START + $signed(div_quo[Z_W-1:0]);
          first_r  <= 1'b1;
          count_r  <= '0;
          inside_r <= 1'b0;
          p_rr_r   <= '0;
          p_ii_r   <= '0;
          p_ri_r   <= '0;
        end
      end
      ST_ITER_ADD: begin
        if (first_r) begin
          zr_r    <= cr_r;
          zi_r    <= ci_r;
          first_r <= 1'b0;
        end else if (!escape) begin
          count_r <= count_inc[ITER_W-1:0];
          zr_r    <= zr_new;
          zi_r    <= zi_new;
          if (last_iter) begin
            inside_r <= 1'b1;
            int_r    <= '0;
          end
        end
      end
      ST_ITER_MUL: begin
        p_rr_r <= zr_r * zr_r;
        p_ii_r <= zi_r * zi_r;
        p_ri_r <= zr_r * zi_r;
      end
      ST_DIV_INT: begin
        if (div_done) int_r <= div_quo[INT_W-1:0];
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_intensity_r <= int_r;
      out_count_r     <= count_r;
      out_inside_r    <= inside_r;
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_intensity       = out_intensity_r;
  assign out_iteration_count = out_count_r;
  assign out_inside_set      = out_inside_r;

`ifndef SYNTHESIS
  a_inside_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_inside_r) |-> (out_intensity_r == '0))
    else $error("inside point with nonzero intensity");

  a_inside_full: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_inside_r) |-> (out_count_r == lim_r))
    else $error("inside point without a full iteration count");

  a_escape_short: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && !out_inside_r) |-> (out_count_r < lim_r))
    else $error("escaped point with count at the limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER_ADD && !first_r) |-> (count_r < lim_r))
    else $error("iteration count ran past the limit");
`endif

endmodule
